@@ hw/rtl/wsts_pkg.sv @@
// ----------------------------------------------------------------------------
// Work-stealing scheduler package
// Shared types and constants for the scheduler front end and back end.
// ----------------------------------------------------------------------------
package wsts_pkg;

	localparam int MAX_WORKERS = 8;
	localparam logic [31:0] RNG_SEED = 32'h9E3779B9;
	localparam logic [31:0] RNG_MUL = 32'd2654435761;
	localparam logic [15:0] PENDING_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		REQ_SUBMIT = 2'd0,
		REQ_FETCH = 2'd1,
		REQ_DONE = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NO_TASK = 3'd1,
		ST_REJECTED = 3'd2,
		ST_NULL = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SRC_OWN = 2'd0,
		SRC_FIFO = 2'd1,
		SRC_STEAL = 2'd2
	} source_t;

	typedef enum logic [0:0] {
		CFG_WORKER_COUNT = 1'd0,
		CFG_ACCEPTING = 1'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DECIDE,
		BK_RNG,
		BK_MOD,
		BK_SCAN,
		BK_READ,
		BK_WAIT,
		BK_OUT
	} bk_state_t;

endpackage

@@ hw/rtl/wsts_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready channel
// A handshake channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface wsts_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/wsts_front.sv @@
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts requests, clamps the worker count, flags own-worker requests and holds a two-entry queue.
// ----------------------------------------------------------------------------
module wsts_front
	import wsts_pkg::*;
#(
	parameter int TASK_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] in_req_type,
	input logic [2:0] in_worker,
	input logic in_on_worker,
	input logic in_in_task,
	input logic [TASK_WIDTH-1:0] in_task_in,
	input logic [3:0] n_workers,
	output logic q_valid,
	input logic q_ready,
	output logic [1:0] q_req_type,
	output logic [2:0] q_worker,
	output logic q_own,
	output logic q_on_worker,
	output logic q_in_task,
	output logic [TASK_WIDTH-1:0] q_task
);
	localparam int EW = 3 + 1 + 1 + 1 + 2 + TASK_WIDTH;

	logic [EW-1:0] mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic own;
	logic [3:0] n_eff;
	logic [EW-1:0] rd;

	assign n_eff = (n_workers == 4'd0) ? 4'd1 :
		((32'(n_workers) > MAX_WORKERS) ? 4'(MAX_WORKERS) : n_workers);
	assign own = in_on_worker && ({1'b0, in_worker} < n_eff);
	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign rd = mem_q[rd_q];
	assign {q_req_type, q_worker, q_own, q_on_worker, q_in_task, q_task} = rd;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mem_q[wr_q] <= {in_req_type, in_worker, own, in_on_worker, in_in_task,
				in_task_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end
endmodule

@@ hw/rtl/wsts_back.sv @@
// ----------------------------------------------------------------------------
// Scheduler back end
// Runs one request at a time against the deques, the FIFO and the counter.
// ----------------------------------------------------------------------------
module wsts_back
	import wsts_pkg::*;
#(
	parameter int DEQUE_DEPTH = 256,
	parameter int FIFO_DEPTH = 256,
	parameter int TASK_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic [3:0] n_workers,
	input logic accepting,
	input logic q_valid,
	output logic q_ready,
	input logic [1:0] q_req_type,
	input logic [2:0] q_worker,
	input logic q_own,
	input logic q_on_worker,
	input logic q_in_task,
	input logic [TASK_WIDTH-1:0] q_task,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] out_status,
	output logic [TASK_WIDTH-1:0] out_task_out,
	output logic [1:0] out_source,
	output logic [2:0] out_victim,
	output logic [15:0] out_outstanding_count
);
	localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int DW = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
	localparam int FW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	logic [TASK_WIDTH-1:0] dmem [MAX_WORKERS*DEQUE_DEPTH];
	logic [TASK_WIDTH-1:0] fmem [FIFO_DEPTH];
	logic [DW:0] top_q [MAX_WORKERS];
	logic [DW:0] bot_q [MAX_WORKERS];
	logic [31:0] rng_q [MAX_WORKERS];
	logic [FW-1:0] fhead_q, ftail_q;
	logic [FW:0] fcnt_q;
	logic [15:0] pend_q;

	bk_state_t state_q, state_d;
	logic [1:0] req_q;
	logic [WW-1:0] wk_q, v_q;
	logic own_q, onw_q, int_q;
	logic [TASK_WIDTH-1:0] task_q;
	logic [31:0] mod_q;
	logic [3:0] n_q, i_q;
	logic [TASK_WIDTH-1:0] dq_rd_q, fq_rd_q;
	logic rd_fifo_q;
	logic [2:0] st_q;
	logic [1:0] src_q;
	logic dwe, fwe, dre, fre;
	logic [WW+DW-1:0] daddr;
	logic [FW-1:0] faddr;

	logic [DW:0] used_w, used_v;
	logic [31:0] x0, x1, x2, x3;
	logic [WW:0] v_inc;

	assign used_w = bot_q[wk_q] - top_q[wk_q];
	assign used_v = bot_q[v_q] - top_q[v_q];
	assign x0 = (rng_q[wk_q] == 32'd0) ? RNG_SEED : rng_q[wk_q];
	assign x1 = x0 ^ (x0 << 13);
	assign x2 = x1 ^ (x1 >> 17);
	assign x3 = x2 ^ (x2 << 5);
	assign v_inc = {1'b0, v_q} + 1'b1;

	assign q_ready = state_q == BK_IDLE;
	assign out_valid = state_q == BK_OUT;

	always_ff @(posedge clk) begin
		if (dwe) dmem[daddr] <= task_q;
		if (dre) dq_rd_q <= dmem[daddr];
		if (fwe) fmem[faddr] <= task_q;
		if (fre) fq_rd_q <= fmem[faddr];
	end

	always_comb begin
		state_d = state_q;
		dwe = 1'b0;
		fwe = 1'b0;
		dre = 1'b0;
		fre = 1'b0;
		daddr = {wk_q, bot_q[wk_q][DW-1:0]};
		faddr = ftail_q;
		case (state_q)
			BK_IDLE: if (q_valid) state_d = BK_DECIDE;
			BK_DECIDE: begin
				state_d = BK_OUT;
				if (req_q == REQ_SUBMIT) begin
					if (task_q != '0 && !(accepting == 1'b0 && !int_q)) begin
						if (own_q && int_q && used_w < (DW+1)'(DEQUE_DEPTH)) begin
							dwe = 1'b1;
						end else if (fcnt_q < (FW+1)'(FIFO_DEPTH)) begin
							fwe = 1'b1;
						end
					end
				end else if (req_q == REQ_FETCH) begin
					if (own_q && used_w != '0) begin
						daddr = {wk_q, bot_q[wk_q][DW-1:0] - DW'(1)};
						dre = 1'b1;
						state_d = BK_WAIT;
					end else if (fcnt_q != '0) begin
						faddr = fhead_q;
						fre = 1'b1;
						state_d = BK_WAIT;
					end else if (own_q && n_q > 4'd1) begin
						state_d = BK_RNG;
					end else if (!onw_q) begin
						state_d = BK_SCAN;
					end
				end
			end
			BK_RNG: state_d = BK_MOD;
			BK_MOD: if (mod_q < 32'(n_q)) state_d = BK_SCAN;
			BK_SCAN: begin
				if (i_q == n_q) begin
					state_d = BK_OUT;
				end else if ((!onw_q || v_q != wk_q) && used_v != '0) begin
					daddr = {v_q, top_q[v_q][DW-1:0]};
					dre = 1'b1;
					state_d = BK_WAIT;
				end
			end
			BK_WAIT: state_d = BK_OUT;
			BK_OUT: if (out_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			for (int k = 0; k < MAX_WORKERS; k++) begin
				top_q[k] <= '0;
				bot_q[k] <= '0;
				rng_q[k] <= RNG_SEED ^ (32'(k) * RNG_MUL);
			end
			fhead_q <= '0;
			ftail_q <= '0;
			fcnt_q <= '0;
			pend_q <= '0;
			st_q <= ST_OK;
			src_q <= SRC_OWN;
			rd_fifo_q <= 1'b0;
			req_q <= REQ_NONE;
			wk_q <= '0;
			v_q <= '0;
			own_q <= 1'b0;
			onw_q <= 1'b0;
			int_q <= 1'b0;
			task_q <= '0;
			mod_q <= '0;
			n_q <= 4'd1;
			i_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				BK_IDLE: begin
					if (q_valid) begin
						req_q <= q_req_type;
						wk_q <= WW'(q_worker);
						own_q <= q_own;
						onw_q <= q_on_worker;
						int_q <= q_in_task;
						task_q <= q_task;
						n_q <= (n_workers == 4'd0) ? 4'd1 :
							((32'(n_workers) > MAX_WORKERS) ? 4'(MAX_WORKERS) : n_workers);
						st_q <= ST_OK;
						src_q <= SRC_OWN;
						rd_fifo_q <= 1'b0;
						i_q <= '0;
						v_q <= '0;
					end
				end
				BK_DECIDE: begin
					if (req_q == REQ_SUBMIT) begin
						if (task_q == '0) st_q <= ST_NULL;
						else if (accepting == 1'b0 && !int_q) st_q <= ST_REJECTED;
						else if (dwe) bot_q[wk_q] <= bot_q[wk_q] + 1'b1;
						else if (fwe) begin
							ftail_q <= ftail_q + 1'b1;
							fcnt_q <= fcnt_q + 1'b1;
						end else st_q <= ST_FULL;
						if (dwe || fwe) begin
							if (pend_q != PENDING_MAX) pend_q <= pend_q + 1'b1;
						end
					end else if (req_q == REQ_FETCH) begin
						if (own_q && used_w != '0) begin
							bot_q[wk_q] <= bot_q[wk_q] - 1'b1;
							src_q <= SRC_OWN;
						end else if (fcnt_q != '0) begin
							fhead_q <= fhead_q + 1'b1;
							fcnt_q <= fcnt_q - 1'b1;
							src_q <= SRC_FIFO;
							rd_fifo_q <= 1'b1;
						end else if (!(own_q && n_q > 4'd1) && onw_q) begin
							st_q <= ST_NO_TASK;
						end
					end else if (req_q == REQ_DONE) begin
						if (pend_q != '0) pend_q <= pend_q - 1'b1;
					end
				end
				BK_RNG: begin
					rng_q[wk_q] <= x3;
					mod_q <= x3;
				end
				BK_MOD: begin
					if (mod_q >= 32'(n_q)) begin
						mod_q <= (mod_q >= (32'(n_q) << 28)) ? mod_q - (32'(n_q) << 28) :
							(mod_q >= (32'(n_q) << 24)) ? mod_q - (32'(n_q) << 24) :
							(mod_q >= (32'(n_q) << 20)) ? mod_q - (32'(n_q) << 20) :
							(mod_q >= (32'(n_q) << 16)) ? mod_q - (32'(n_q) << 16) :
							(mod_q >= (32'(n_q) << 12)) ? mod_q - (32'(n_q) << 12) :
							(mod_q >= (32'(n_q) << 8)) ? mod_q - (32'(n_q) << 8) :
							(mod_q >= (32'(n_q) << 4)) ? mod_q - (32'(n_q) << 4) :
							mod_q - 32'(n_q);
					end else begin
						v_q <= WW'(mod_q);
					end
				end
				BK_SCAN: begin
					if (i_q == n_q) begin
						st_q <= ST_NO_TASK;
					end else if ((!onw_q || v_q != wk_q) && used_v != '0) begin
						top_q[v_q] <= top_q[v_q] + 1'b1;
						src_q <= SRC_STEAL;
					end else begin
						i_q <= i_q + 1'b1;
						v_q <= ((WW+1)'(v_inc) == (WW+1)'(n_q)) ? '0 : WW'(v_inc);
					end
				end
				default: ;
			endcase
		end
	end

	assign out_status = st_q;
	assign out_task_out = (st_q != ST_OK || req_q != REQ_FETCH) ? '0 :
		(rd_fifo_q ? fq_rd_q : dq_rd_q);
	assign out_source = (st_q == ST_OK && req_q == REQ_FETCH) ? src_q : SRC_OWN;
	assign out_victim = (st_q == ST_OK && req_q == REQ_FETCH && src_q == SRC_STEAL) ?
		3'(v_q) : 3'd0;
	assign out_outstanding_count = pend_q;
endmodule

@@ hw/rtl/work_stealing_task_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// Work-stealing task scheduler
// Per-worker ring deques and a shared FIFO behind a request/response port.
// ----------------------------------------------------------------------------
// Requests are served one at a time. A stealing fetch from a worker runs the
// generator step and a remainder reduction before it scans the deques. The
// front queue holds two requests.
module work_stealing_task_scheduler_top
	import wsts_pkg::*;
#(
	parameter int DEQUE_DEPTH = 256,
	parameter int FIFO_DEPTH = 256,
	parameter int TASK_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	input logic [2:0] worker,
	input logic on_worker,
	input logic in_task,
	input logic [TASK_WIDTH-1:0] task_in,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] status,
	output logic [TASK_WIDTH-1:0] task_out,
	output logic [1:0] source,
	output logic [2:0] victim,
	output logic [15:0] outstanding_count,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [3:0] cfg_data
);
	logic [3:0] wcount_q;
	logic accepting_q;
	logic qv, qr, q_own, q_onw, q_int;
	logic [1:0] q_req;
	logic [2:0] q_wk;
	logic [TASK_WIDTH-1:0] q_task;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q <= 4'd8;
			accepting_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WORKER_COUNT: wcount_q <= cfg_data;
				CFG_ACCEPTING: accepting_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	wsts_front #(.TASK_WIDTH(TASK_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.in_req_type(req_type), .in_worker(worker), .in_on_worker(on_worker),
		.in_in_task(in_task), .in_task_in(task_in), .n_workers(wcount_q),
		.q_valid(qv), .q_ready(qr), .q_req_type(q_req), .q_worker(q_wk),
		.q_own(q_own), .q_on_worker(q_onw), .q_in_task(q_int), .q_task(q_task)
	);

	wsts_back #(.DEQUE_DEPTH(DEQUE_DEPTH),
		.FIFO_DEPTH(FIFO_DEPTH), .TASK_WIDTH(TASK_WIDTH)) u_back (
		.clk, .arst_n, .n_workers(wcount_q), .accepting(accepting_q),
		.q_valid(qv), .q_ready(qr), .q_req_type(q_req), .q_worker(q_wk),
		.q_own(q_own), .q_on_worker(q_onw), .q_in_task(q_int), .q_task(q_task),
		.out_valid, .out_ready, .out_status(status), .out_task_out(task_out),
		.out_source(source), .out_victim(victim),
		.out_outstanding_count(outstanding_count)
	);
endmodule

@@ tb/tb_work_stealing_task_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Work-stealing task scheduler testbench
// Drives submit, fetch and completion requests through valid/ready channels
// and checks every response against a fixed expectation or a cycle-free predictor
// of the deques, the shared FIFO and the steal generators, over several register settings.
// ----------------------------------------------------------------------------
module tb_work_stealing_task_scheduler_top;
	import wsts_pkg::*;

	typedef struct packed {
		logic [1:0] rt;
		logic [2:0] wk;
		logic onw;
		logic intk;
		logic [31:0] tsk;
	} sched_req_s;

	typedef struct packed {
		logic [2:0] st;
		logic [31:0] tout;
		logic [1:0] src;
		logic [2:0] vic;
		logic [15:0] cnt;
	} sched_rsp_s;

	typedef struct packed {
		sched_req_s r;
		logic typed;
		sched_rsp_s e;
	} dir_row_s;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [3:0] cfg_data;

	wsts_if #(.T(sched_req_s)) req_ch ();
	wsts_if #(.T(sched_rsp_s)) rsp_ch ();

	work_stealing_task_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req_ch.valid),
		.in_ready(req_ch.ready),
		.req_type(req_ch.payload.rt),
		.worker(req_ch.payload.wk),
		.on_worker(req_ch.payload.onw),
		.in_task(req_ch.payload.intk),
		.task_in(req_ch.payload.tsk),
		.out_valid(rsp_ch.valid),
		.out_ready(rsp_ch.ready),
		.status(rsp_ch.payload.st),
		.task_out(rsp_ch.payload.tout),
		.source(rsp_ch.payload.src),
		.victim(rsp_ch.payload.vic),
		.outstanding_count(rsp_ch.payload.cnt),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted scheduler state.
	logic [31:0] dq_mem [8][256];
	logic [8:0] dq_top [8];
	logic [8:0] dq_bot [8];
	logic [31:0] steal_gen [8];
	logic [31:0] shared_fifo [256];
	logic [7:0] sf_head;
	logic [7:0] sf_tail;
	logic [8:0] sf_count;
	logic [15:0] pending;
	logic [3:0] wcount_reg;
	logic accept_reg;

	sched_rsp_s expected_rsp [$];
	int errors = 0;
	int rsp_seen = 0;
	int cycles = 0;
	bit burst_mode = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("work_stealing_task_scheduler_top: mismatch");
			$finish;
		end
	end

	function automatic logic [8:0] dq_used(int w);
		return dq_bot[w] - dq_top[w];
	endfunction

	function automatic sched_rsp_s predict_response(sched_req_s r);
		sched_rsp_s o;
		int n;
		int v;
		bit own;
		bit found;
		logic [31:0] x;
		o = '0;
		found = 0;
		n = (wcount_reg == 0) ? 1 : (wcount_reg > 8) ? 8 : int'(wcount_reg);
		own = r.onw && (int'(r.wk) < n);
		case (r.rt)
			REQ_SUBMIT: begin
				if (r.tsk == 0) begin
					o.st = ST_NULL;
				end else if (!accept_reg && !r.intk) begin
					o.st = ST_REJECTED;
				end else if (own && r.intk && dq_used(r.wk) < 256) begin
					dq_mem[r.wk][dq_bot[r.wk][7:0]] = r.tsk;
					dq_bot[r.wk] = dq_bot[r.wk] + 9'd1;
					o.st = ST_OK;
				end else if (sf_count < 256) begin
					shared_fifo[sf_tail] = r.tsk;
					sf_tail = sf_tail + 8'd1;
					sf_count = sf_count + 9'd1;
					o.st = ST_OK;
				end else begin
					o.st = ST_FULL;
				end
				if (o.st == ST_OK && pending != PENDING_MAX) pending = pending + 16'd1;
			end
			REQ_FETCH: begin
				if (own && dq_used(r.wk) != 0) begin
					dq_bot[r.wk] = dq_bot[r.wk] - 9'd1;
					o.tout = dq_mem[r.wk][dq_bot[r.wk][7:0]];
					o.src = SRC_OWN;
					found = 1;
				end
				if (!found && sf_count != 0) begin
					o.tout = shared_fifo[sf_head];
					sf_head = sf_head + 8'd1;
					sf_count = sf_count - 9'd1;
					o.src = SRC_FIFO;
					found = 1;
				end
				if (!found && own && n > 1) begin
					x = steal_gen[r.wk];
					if (x == 0) x = RNG_SEED;
					x = x ^ (x << 13);
					x = x ^ (x >> 17);
					x = x ^ (x << 5);
					steal_gen[r.wk] = x;
					v = int'(x % n);
					for (int i = 0; i < n && !found; i++) begin
						if (v != int'(r.wk) && dq_used(v) != 0) begin
							o.tout = dq_mem[v][dq_top[v][7:0]];
							dq_top[v] = dq_top[v] + 9'd1;
							o.src = SRC_STEAL;
							o.vic = 3'(v);
							found = 1;
						end else begin
							v = (v + 1) % n;
						end
					end
				end
				if (!found && !r.onw) begin
					for (int i = 0; i < n && !found; i++) begin
						if (dq_used(i) != 0) begin
							o.tout = dq_mem[i][dq_top[i][7:0]];
							dq_top[i] = dq_top[i] + 9'd1;
							o.src = SRC_STEAL;
							o.vic = 3'(i);
							found = 1;
						end
					end
				end
				if (!found) begin
					o.st = ST_NO_TASK;
					o.tout = 0;
					o.src = SRC_OWN;
					o.vic = 0;
				end
			end
			REQ_DONE: begin
				if (pending != 0) pending = pending - 16'd1;
			end
			default: ;
		endcase
		o.cnt = pending;
		return o;
	endfunction

	task automatic report(string field, int idx, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("ERROR response %0d: %s is %0h, expected %0h", idx, field, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp.size() == 0) begin
				errors++;
				$display("ERROR response %0d arrived with nothing expected", rsp_seen);
			end else begin
				sched_rsp_s e;
				e = expected_rsp.pop_front();
				if (rsp_ch.payload.st !== e.st)
					report("status", rsp_seen, 32'(rsp_ch.payload.st), 32'(e.st));
				if (rsp_ch.payload.tout !== e.tout)
					report("task_out", rsp_seen, rsp_ch.payload.tout, e.tout);
				if (rsp_ch.payload.src !== e.src)
					report("source", rsp_seen, 32'(rsp_ch.payload.src), 32'(e.src));
				if (rsp_ch.payload.vic !== e.vic)
					report("victim", rsp_seen, 32'(rsp_ch.payload.vic), 32'(e.vic));
				if (rsp_ch.payload.cnt !== e.cnt)
					report("outstanding_count", rsp_seen, 32'(rsp_ch.payload.cnt),
						32'(e.cnt));
			end
			rsp_seen <= rsp_seen + 1;
		end
	end

	// Response side: random stalls, plus one long hold-off that backs up the request path.
	initial begin
		int gap;
		bit held;
		held = 0;
		rsp_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			gap = burst_mode ? 0 : $urandom_range(0, 14);
			if (!held && rsp_seen >= 300) begin
				held = 1;
				rsp_ch.ready <= 0;
				repeat (600) @(posedge clk);
			end else if (gap > 0) begin
				rsp_ch.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	task automatic send_request(sched_req_s r, logic typed, sched_rsp_s e);
		int gap;
		sched_rsp_s p;
		gap = burst_mode ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		p = predict_response(r);
		expected_rsp.push_back(typed ? e : p);
		req_ch.valid <= 1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [3:0] val);
		req_ch.valid <= 0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == CFG_WORKER_COUNT) wcount_reg = val;
		else accept_reg = val[0];
	endtask

	function automatic sched_req_s random_request();
		sched_req_s r;
		int k;
		k = $urandom_range(0, 99);
		r.rt = (k < 46) ? REQ_SUBMIT : (k < 90) ? REQ_FETCH : (k < 98) ? REQ_DONE : REQ_NONE;
		r.wk = 3'($urandom_range(0, 7));
		r.onw = ($urandom_range(0, 9) < 8);
		r.intk = ($urandom_range(0, 9) < 7);
		k = $urandom_range(0, 99);
		r.tsk = (k < 5) ? 32'h0 : (k < 8) ? 32'hFFFF_FFFF : $urandom;
		return r;
	endfunction

	function automatic sched_req_s make_req(req_t rt, int wk, bit onw, bit intk, logic [31:0] t);
		sched_req_s r;
		r.rt = rt;
		r.wk = 3'(wk);
		r.onw = onw;
		r.intk = intk;
		r.tsk = t;
		return r;
	endfunction

	initial begin
		dir_row_s rows [$];
		dir_row_s row;
		sched_req_s r;
		int wcs [7] = '{1, 0, 15, 3, 5, 2, 8};
		int acc_set [7] = '{1, 1, 0, 0, 1, 1, 1};

		arst_n = 0;
		cfg_valid = 0;
		cfg_index = CFG_WORKER_COUNT;
		cfg_data = 0;
		req_ch.valid = 0;
		req_ch.payload = '0;
		for (int i = 0; i < 8; i++) begin
			dq_top[i] = 0;
			dq_bot[i] = 0;
			steal_gen[i] = RNG_SEED ^ (32'(i) * RNG_MUL);
		end
		sf_head = 0;
		sf_tail = 0;
		sf_count = 0;
		pending = 0;
		wcount_reg = 8;
		accept_reg = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		row = '0;
		row.typed = 1;
		row.r = make_req(REQ_FETCH, 0, 0, 0, 0);
		row.e.st = ST_NO_TASK;
		rows.push_back(row);
		row.r = make_req(REQ_SUBMIT, 7, 1, 1, 0);
		row.e.st = ST_NULL;
		rows.push_back(row);
		row.r = make_req(REQ_DONE, 0, 0, 0, 0);
		row.e.st = ST_OK;
		rows.push_back(row);
		row.r = make_req(REQ_NONE, 7, 1, 1, 32'hFFFF_FFFF);
		rows.push_back(row);
		row.typed = 0;
		row.e = '0;
		row.r = make_req(REQ_SUBMIT, 2, 1, 1, 32'hFFFF_FFFF); rows.push_back(row);
		row.r = make_req(REQ_SUBMIT, 2, 1, 1, 32'h0000_0001); rows.push_back(row);
		row.r = make_req(REQ_SUBMIT, 0, 0, 0, 32'h8000_0000); rows.push_back(row);
		row.r = make_req(REQ_SUBMIT, 6, 1, 0, 32'h1234_5678); rows.push_back(row);
		row.r = make_req(REQ_FETCH, 2, 1, 0, 0); rows.push_back(row);
		row.r = make_req(REQ_FETCH, 2, 1, 0, 0); rows.push_back(row);
		row.r = make_req(REQ_FETCH, 2, 1, 0, 0); rows.push_back(row);
		row.r = make_req(REQ_SUBMIT, 5, 1, 1, 32'hA5A5_5A5A); rows.push_back(row);
		row.r = make_req(REQ_SUBMIT, 5, 1, 1, 32'h5A5A_A5A5); rows.push_back(row);
		row.r = make_req(REQ_SUBMIT, 3, 1, 1, 32'h0F0F_F0F0); rows.push_back(row);
		row.r = make_req(REQ_FETCH, 0, 1, 0, 0); rows.push_back(row);
		row.r = make_req(REQ_FETCH, 0, 0, 0, 0); rows.push_back(row);
		row.r = make_req(REQ_FETCH, 7, 1, 1, 0); rows.push_back(row);
		row.r = make_req(REQ_FETCH, 0, 0, 1, 0); rows.push_back(row);
		row.r = make_req(REQ_FETCH, 4, 1, 0, 0); rows.push_back(row);
		for (int i = 0; i < 7; i++) begin
			row.r = make_req(REQ_DONE, i, i[0], 0, 0);
			rows.push_back(row);
		end
		foreach (rows[i]) send_request(rows[i].r, rows[i].typed, rows[i].e);

		// Fill one deque and the FIFO to capacity, then send a rejected submit and random submits and fetches.
		write_register(CFG_WORKER_COUNT, 4'd1);
		burst_mode = 1;
		for (int i = 0; i < 540; i++) begin
			r = make_req(REQ_SUBMIT, 0, 1, 1, $urandom | 32'h1);
			send_request(r, 0, '0);
		end
		burst_mode = 0;
		write_register(CFG_ACCEPTING, 4'd0);
		r = make_req(REQ_SUBMIT, 0, 0, 0, 32'h7);
		send_request(r, 0, '0);
		for (int i = 0; i < 120; i++) begin
			r = random_request();
			r.rt = ($urandom_range(0, 3) == 0) ? REQ_SUBMIT : REQ_FETCH;
			send_request(r, 0, '0);
		end

		foreach (wcs[p]) begin
			write_register(CFG_WORKER_COUNT, 4'(wcs[p]));
			write_register(CFG_ACCEPTING, 4'(acc_set[p]));
			for (int i = 0; i < 130; i++) begin
				burst_mode = (i >= 60 && i < 80);
				send_request(random_request(), 0, '0);
			end
			burst_mode = 0;
		end

		req_ch.valid <= 0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("work_stealing_task_scheduler_top: match");
		end else begin
			$display("work_stealing_task_scheduler_top: mismatch");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/wsts_pkg.sv
hw/rtl/wsts_if.sv
hw/rtl/wsts_front.sv
hw/rtl/wsts_back.sv
hw/rtl/work_stealing_task_scheduler_top.sv
tb/tb_work_stealing_task_scheduler_top.sv
